@@ rtl/osa_pkg.sv @@
// ----------------------------------------------------------------------------
// osa_pkg
// shared types and constants of the owned slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package osa_pkg;

  // default sizing of the slot table
  localparam int unsigned OSA_ENTRIES         = 8;
  localparam int unsigned OSA_MAX_STACK_BYTES = 1024;
  localparam int unsigned OSA_ALIGN_BYTES     = 8;
  localparam int unsigned OSA_GUARD_BYTES     = 8;

  // configuration port
  localparam int unsigned OSA_ADDR_W = 3;
  localparam int unsigned OSA_DATA_W = 32;
  localparam logic        REG_POOL_BASE = 1'b0;  // word index of pool base register

  // request kinds
  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_BAD  = 3'd1,
    ST_DUP  = 3'd2,
    ST_FULL = 3'd3,
    ST_MISS = 3'd4
  } osa_status_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] stack_size;
    logic [31:0] owner_tag;
    logic [7:0]  slot_handle;
  } osa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  handle_out;
    logic [31:0] limit_address;
    logic [31:0] top_address;
    logic [31:0] pointer_address;
    logic [10:0] size_out;
  } osa_rsp_t;

endpackage

`default_nettype wire

@@ rtl/owned_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// owned_slot_allocator_unit
// fixed table of stack slots tagged with an owner: allocate and look up
// ----------------------------------------------------------------------------
// allocate: alignment check (size times reciprocal, quotient times alignment,
//   compare), then the one-entry-per-cycle owner scan of the slot ram; a bad
//   size or owner, an owner already held or a full table ends in a failure
// lookup: one ram read, then multiply and two adds, a miss ends in a failure
// throughput: one request at a time, busy until the result is out, no stall
// reset: all slots free and pool base zero at once; no clearing pass
`default_nettype none

module owned_slot_allocator_unit
  import osa_pkg::*;
#(
  parameter int unsigned ENTRIES         = OSA_ENTRIES,
  parameter int unsigned MAX_STACK_BYTES = OSA_MAX_STACK_BYTES,
  parameter int unsigned ALIGN_BYTES     = OSA_ALIGN_BYTES,
  parameter int unsigned GUARD_BYTES     = OSA_GUARD_BYTES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire osa_req_t              req_i,
  // result channel
  output logic                       done_o,
  output osa_rsp_t                   rsp_o,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [OSA_ADDR_W-1:0] paddr,
  input  wire logic [OSA_DATA_W-1:0] pwdata,
  output logic      [OSA_DATA_W-1:0] prdata,
  output logic                       pready
);

  // table indexing
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned STRIDE = MAX_STACK_BYTES + GUARD_BYTES;
  // alignment check by reciprocal: q = (size * ALN_MUL) >> ALN_SH is exact for
  // every 16-bit size, then q * ALIGN_BYTES equals size only when aligned
  localparam int unsigned ALN_SH = 16 + $clog2(ALIGN_BYTES);
  localparam longint unsigned ALN_MUL =
    ((64'd1 << ALN_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int unsigned RAM_W = 32 + 16;

  // sequencer
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ALQ  = 10'b00_0000_0010,  // size times reciprocal
    S_ALR  = 10'b00_0000_0100,  // quotient times alignment
    S_ALC  = 10'b00_0000_1000,  // alignment compare
    S_SCAN = 10'b00_0001_0000,  // owner scan and free slot search
    S_LKUP = 10'b00_0010_0000,  // lookup compare
    S_MUL  = 10'b00_0100_0000,  // index times stride
    S_ADDL = 10'b00_1000_0000,  // limit = base + offset
    S_ADDT = 10'b01_0000_0000,  // top = limit + size, emit
    S_FAIL = 10'b10_0000_0000   // emit failure
  } state_e;

  state_e           state_q, state_d;
  osa_req_t         req_q, req_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             have_free_q, have_free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      size_q, size_d;
  logic [47:0]      prod_q, prod_d;
  logic [31:0]      limit_q, limit_d;
  osa_status_e      st_q, st_d;
  logic             done_q, done_d;
  osa_rsp_t         rsp_q, rsp_d;
  logic [ENTRIES-1:0] in_use_q, in_use_d;
  logic [31:0]      base_q;

  // shared arithmetic
  logic [15:0]      mul_a;
  logic [31:0]      mul_b;
  logic [31:0]      add_a, add_b, add_sum;
  logic [15:0]      quo;

  // slot ram: owner tag and size per slot
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  logic [31:0]      rd_owner;
  logic [15:0]      rd_size;

  logic             accept;
  logic [7:0]       handle_m1;
  logic             used;
  logic             hf;
  logic [IDX_W-1:0] fi;
  logic [3:0]       handle_enc;
  logic             cfg_wr;

  assign accept    = start && !busy;
  assign handle_m1 = req_i.slot_handle - 8'd1;
  assign rd_owner  = ram_rdata[RAM_W-1:16];
  assign rd_size   = ram_rdata[15:0];
  assign quo       = prod_q[ALN_SH +: 16];
  assign handle_enc = 4'({1'b0, idx_q} + (IDX_W + 1)'(1));

  osa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one multiplier, operands chosen by state
  always_comb begin
    unique case (1'b1)
      state_q[4'd2]: begin  // S_ALR
        mul_a = quo;
        mul_b = 32'(ALIGN_BYTES);
      end
      state_q[4'd6]: begin  // S_MUL
        mul_a = 16'(idx_q);
        mul_b = 32'(STRIDE);
      end
      default: begin
        mul_a = req_q.stack_size;
        mul_b = 32'(ALN_MUL);
      end
    endcase
  end

  assign prod_d = {32'd0, mul_a} * {16'd0, mul_b};

  // one adder: base + offset, then limit + size
  assign add_a   = (state_q == S_ADDT) ? limit_q : base_q;
  assign add_b   = (state_q == S_ADDT) ? {16'd0, size_q} : prod_q[31:0];
  assign add_sum = add_a + add_b;

  // ram read address: handle at accept, scan counter otherwise
  assign ram_raddr = (state_q == S_IDLE) ? handle_m1[IDX_W-1:0] : cnt_q[IDX_W-1:0];
  assign ram_wdata = {req_q.owner_tag, req_q.stack_size};
  assign ram_waddr = fi;

  // scan bookkeeping for the entry whose data is on the ram output
  assign used = in_use_q[cmp_idx_q];
  assign hf   = have_free_q || !used;
  assign fi   = have_free_q ? free_idx_q : cmp_idx_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    idx_d       = idx_q;
    size_d      = size_q;
    limit_d     = limit_q;
    st_d        = st_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    in_use_d    = in_use_q;
    ram_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          idx_d = handle_m1[IDX_W-1:0];
          if (req_i.kind == KIND_ALLOC) begin
            if (req_i.owner_tag == 32'd0 || req_i.stack_size == 16'd0 ||
                req_i.stack_size > 16'(MAX_STACK_BYTES)) begin
              st_d    = ST_BAD;
              state_d = S_FAIL;
            end else begin
              state_d = S_ALQ;
            end
          end else begin
            if (req_i.slot_handle == 8'd0 || req_i.slot_handle > 8'(ENTRIES) ||
                req_i.owner_tag == 32'd0) begin
              st_d    = ST_MISS;
              state_d = S_FAIL;
            end else begin
              state_d = S_LKUP;
            end
          end
        end
      end
      S_ALQ: begin
        state_d = S_ALR;
      end
      S_ALR: begin
        state_d = S_ALC;
      end
      S_ALC: begin
        if (prod_q[15:0] != req_q.stack_size) begin
          st_d    = ST_BAD;
          state_d = S_FAIL;
        end else begin
          cnt_d       = '0;
          cmp_vld_d   = 1'b0;
          have_free_d = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the next read while comparing the previous one
        cmp_vld_d = cnt_q < CNT_W'(ENTRIES);
        cmp_idx_d = cnt_q[IDX_W-1:0];
        if (cnt_q < CNT_W'(ENTRIES)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (cmp_vld_q) begin
          if (used && rd_owner == req_q.owner_tag) begin
            st_d    = ST_DUP;
            state_d = S_FAIL;
          end else begin
            have_free_d = hf;
            free_idx_d  = fi;
            if (cmp_idx_q == IDX_W'(ENTRIES - 1)) begin
              if (!hf) begin
                st_d    = ST_FULL;
                state_d = S_FAIL;
              end else begin
                ram_we       = 1'b1;
                in_use_d[fi] = 1'b1;
                idx_d        = fi;
                size_d       = req_q.stack_size;
                state_d      = S_MUL;
              end
            end
          end
        end
      end
      S_LKUP: begin
        if (in_use_q[idx_q] && rd_owner == req_q.owner_tag) begin
          size_d  = rd_size;
          state_d = S_MUL;
        end else begin
          st_d    = ST_MISS;
          state_d = S_FAIL;
        end
      end
      S_MUL: begin
        state_d = S_ADDL;
      end
      S_ADDL: begin
        limit_d = add_sum;
        state_d = S_ADDT;
      end
      S_ADDT: begin
        rsp_d.status          = ST_OK;
        rsp_d.handle_out      = handle_enc;
        rsp_d.limit_address   = limit_q;
        rsp_d.top_address     = add_sum;
        rsp_d.pointer_address = add_sum;
        rsp_d.size_out        = size_q[10:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_FAIL: begin
        rsp_d        = '0;
        rsp_d.status = st_q;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_use_q <= '0;
      done_q   <= 1'b0;
      base_q   <= '0;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      done_q   <= done_d;
      if (cfg_wr) begin
        base_q <= pwdata;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    cnt_q       <= cnt_d;
    cmp_vld_q   <= cmp_vld_d;
    cmp_idx_q   <= cmp_idx_d;
    have_free_q <= have_free_d;
    free_idx_q  <= free_idx_d;
    idx_q       <= idx_d;
    size_q      <= size_d;
    limit_q     <= limit_d;
    st_q        <= st_d;
    rsp_q       <= rsp_d;
    if (state_q == S_ALQ || state_q == S_ALR || state_q == S_MUL) begin
      prod_q <= prod_d;
    end
  end

  // configuration port: the pool base register only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_BASE);
  assign prdata = (paddr[2] == REG_POOL_BASE) ? base_q : '0;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTH
  // a failed request carries nothing but its status
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |->
      (rsp_o.handle_out == 4'd0 && rsp_o.limit_address == 32'd0 &&
       rsp_o.size_out == 11'd0))
    else $error("failed result carries nonzero fields");

  // a granted slot never has handle zero
  a_ok_handle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_OK) |-> rsp_o.handle_out != 4'd0)
    else $error("ok result with handle zero");

  // an accepted request keeps the unit busy
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // slots are never freed
  a_in_use_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_use_q & ~$past(in_use_q)) == in_use_q) || ($past(in_use_q) == '0) ||
    ((in_use_q & $past(in_use_q)) == $past(in_use_q)))
    else $error("slot released");

  // a result is shown for one cycle only
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");
`endif

endmodule

`default_nettype wire

@@ rtl/osa_ram.sv @@
// ----------------------------------------------------------------------------
// osa_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module osa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for owned_slot_allocator_unit: directed allocate and
// lookup requests, then random traffic under several idle patterns, each
// result compared field by field against a behavioural slot table model
// ----------------------------------------------------------------------------

module tb;
  import osa_pkg::*;

  // cycles without any accepted request or result before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // settle time after the last result, a little above the allocate latency
  localparam int unsigned TAIL_CYCLES    = OSA_ENTRIES + 12;
  // random requests per traffic phase
  localparam int unsigned PHASE_REQUESTS = 630;
  // byte address of the pool base register
  localparam logic [OSA_ADDR_W-1:0] POOL_BASE_ADDR = OSA_ADDR_W'(4 * int'(REG_POOL_BASE));
  // byte distance from one slot's limit to the next
  localparam logic [31:0] SLOT_STRIDE = 32'(OSA_MAX_STACK_BYTES + OSA_GUARD_BYTES);

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  osa_req_t              req_i   = '0;
  logic                  done_o;
  osa_rsp_t              rsp_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [OSA_ADDR_W-1:0] paddr   = '0;
  logic [OSA_DATA_W-1:0] pwdata  = '0;
  logic [OSA_DATA_W-1:0] prdata;
  logic                  pready;

  // slot table model, mirrors the block's state and configuration
  logic        slot_used_m  [OSA_ENTRIES];
  logic [31:0] slot_owner_m [OSA_ENTRIES];
  logic [10:0] slot_size_m  [OSA_ENTRIES];
  logic [31:0] pool_base_m;

  // results still owed by the block, oldest first
  osa_rsp_t    expected_rsp_q[$];

  int unsigned error_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned base_writes     = 0;
  int unsigned status_count[5] = '{default: 0};
  int unsigned idle_cycles     = 0;

  owned_slot_allocator_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // slot table model
  // --------------------------------------------------------------------------

  // works out the result of one request and applies its effect on the table
  function automatic osa_rsp_t predict_slot_result(input osa_req_t req);
    osa_rsp_t rsp;
    int       free_idx;
    int       hit_idx;
    rsp      = '0;
    free_idx = -1;
    if (req.kind == KIND_ALLOC) begin
      // zero owner, zero size, oversize or misaligned size: rejected outright
      if (req.owner_tag == '0 || req.stack_size == '0 ||
          req.stack_size > OSA_MAX_STACK_BYTES ||
          (req.stack_size % OSA_ALIGN_BYTES) != 0) begin
        rsp.status = ST_BAD;
        return rsp;
      end
      // an owner holding a slot wins over a full table
      for (int i = 0; i < OSA_ENTRIES; i++) begin
        if (slot_used_m[i]) begin
          if (slot_owner_m[i] == req.owner_tag) begin
            rsp.status = ST_DUP;
            return rsp;
          end
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (free_idx < 0) begin
        rsp.status = ST_FULL;
        return rsp;
      end
      slot_used_m[free_idx]  = 1'b1;
      slot_owner_m[free_idx] = req.owner_tag;
      slot_size_m[free_idx]  = 11'(req.stack_size);
      hit_idx                = free_idx;
    end else begin
      // handle out of range, zero owner, free slot or foreign owner all miss
      if (req.slot_handle == '0 || req.slot_handle > OSA_ENTRIES ||
          req.owner_tag == '0) begin
        rsp.status = ST_MISS;
        return rsp;
      end
      hit_idx = int'(req.slot_handle) - 1;
      if (!slot_used_m[hit_idx] || slot_owner_m[hit_idx] != req.owner_tag) begin
        rsp.status = ST_MISS;
        return rsp;
      end
    end
    // addresses wrap at 32 bits, as the hardware adders do
    rsp.status          = ST_OK;
    rsp.handle_out      = 4'(hit_idx + 1);
    rsp.limit_address   = pool_base_m + 32'(hit_idx) * SLOT_STRIDE;
    rsp.top_address     = rsp.limit_address + 32'(slot_size_m[hit_idx]);
    rsp.pointer_address = rsp.top_address;
    rsp.size_out        = slot_size_m[hit_idx];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------

  // unused fields carry random bits so that the block is seen to ignore them
  function automatic osa_req_t make_alloc(input logic [15:0] size, input logic [31:0] owner);
    osa_req_t req;
    req.kind        = KIND_ALLOC;
    req.stack_size  = size;
    req.owner_tag   = owner;
    req.slot_handle = 8'($urandom_range(255));
    return req;
  endfunction

  function automatic osa_req_t make_lookup(input logic [7:0] handle, input logic [31:0] owner);
    osa_req_t req;
    req.kind        = KIND_LOOKUP;
    req.stack_size  = 16'($urandom_range(65535));
    req.owner_tag   = owner;
    req.slot_handle = handle;
    return req;
  endfunction

  // mostly well-formed requests, naming owners that the table already knows
  // or random ones, with a share of zero owners, odd sizes and wild handles
  function automatic osa_req_t random_request();
    logic [15:0] size;
    logic [31:0] owner;
    logic [7:0]  handle;
    int unsigned pick;
    pick = $urandom_range(OSA_ENTRIES - 1);
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(9))
        0:       size = 16'($urandom_range(65535));
        1:       size = 16'(OSA_ALIGN_BYTES * $urandom_range(OSA_MAX_STACK_BYTES / OSA_ALIGN_BYTES)
                        + $urandom_range(OSA_ALIGN_BYTES - 1, 1));
        2:       size = 16'(OSA_MAX_STACK_BYTES + OSA_ALIGN_BYTES * $urandom_range(8, 1));
        3:       size = ($urandom_range(1) == 0) ? 16'd0 : 16'(OSA_MAX_STACK_BYTES);
        default: size = 16'(OSA_ALIGN_BYTES * $urandom_range(OSA_MAX_STACK_BYTES / OSA_ALIGN_BYTES, 1));
      endcase
      case ($urandom_range(9))
        0:           owner = '0;
        1, 2, 3, 4:  owner = slot_owner_m[pick];
        default:     owner = 32'($urandom());
      endcase
      return make_alloc(size, owner);
    end
    handle = ($urandom_range(3) != 0) ? 8'($urandom_range(OSA_ENTRIES, 1))
                                      : 8'($urandom_range(255));
    case ($urandom_range(9))
      0:       owner = '0;
      1, 2:    owner = 32'($urandom());
      3:       owner = slot_owner_m[pick];
      default: owner = (handle != '0 && handle <= OSA_ENTRIES) ? slot_owner_m[handle - 1]
                                                              : 32'($urandom());
    endcase
    return make_lookup(handle, owner);
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // presents one request, optionally after an idle gap, and waits until the
  // block takes it; start stays high so a back-to-back request follows at once
  task automatic send_request(input osa_req_t req, input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    expected_rsp_q.push_back(predict_slot_result(req));
    requests_sent++;
  endtask

  // holds requests back until every owed result has come and the block is idle
  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  // write the pool base register, then read it back
  task automatic write_pool_base(input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= POOL_BASE_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pool_base_m = value;
    base_writes++;
    // straight into the setup cycle of the read
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t: pool base readback mismatch, expected %08h, actual %08h",
               $time, value, readback);
      error_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
      error_count++;
    end
  endtask

  // every strobed result is held against the oldest owed one
  always @(posedge clk_i) begin
    osa_rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, rsp_o);
        error_count++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        check_field("status",          32'(exp_rsp.status),     32'(rsp_o.status));
        check_field("handle_out",      32'(exp_rsp.handle_out), 32'(rsp_o.handle_out));
        check_field("limit_address",   exp_rsp.limit_address,   rsp_o.limit_address);
        check_field("top_address",     exp_rsp.top_address,     rsp_o.top_address);
        check_field("pointer_address", exp_rsp.pointer_address, rsp_o.pointer_address);
        check_field("size_out",        32'(exp_rsp.size_out),   32'(rsp_o.size_out));
        if (exp_rsp.status < 5) status_count[exp_rsp.status]++;
        results_checked++;
      end
    end
  end

  // watchdog: a stuck handshake ends the run
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results owed", $time, expected_rsp_q.size());
      $display("owned_slot_allocator_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // lookups against a freshly reset table all miss
  task automatic test_empty_table();
    send_request(make_lookup(8'd1, 32'h0000_0001), 0);
    send_request(make_lookup(8'd0, 32'h0000_0000), 0);
    send_request(make_lookup(8'hFF, 32'hFFFF_FFFF), 0);
  endtask

  // zero owner, zero size, oversize and misaligned sizes are rejected
  task automatic test_bad_allocations();
    send_request(make_alloc(16'(OSA_ALIGN_BYTES), 32'h0000_0000), 0);
    send_request(make_alloc(16'd0, 32'h1234_5678), 0);
    send_request(make_alloc(16'(OSA_MAX_STACK_BYTES + OSA_ALIGN_BYTES), 32'h1234_5678), 0);
    send_request(make_alloc(16'(OSA_ALIGN_BYTES + OSA_ALIGN_BYTES / 2), 32'h1234_5678), 0);
    send_request(make_alloc(16'hFFFF, 32'h1234_5678), 0);
  endtask

  // fill every slot, with a repeated owner while slots are still free,
  // then a newcomer on the full table and a repeated owner on the full table
  task automatic test_fill_and_overflow();
    send_request(make_alloc(16'(OSA_ALIGN_BYTES), 32'hFFFF_FFFF), 0);
    send_request(make_alloc(16'(OSA_MAX_STACK_BYTES), 32'h0000_0001), 0);
    send_request(make_alloc(16'(2 * OSA_ALIGN_BYTES), 32'hA5A5_5A5A), 0);
    send_request(make_alloc(16'(OSA_ALIGN_BYTES), 32'h0000_0001), 0);
    send_request(make_alloc(16'(OSA_MAX_STACK_BYTES / 2), 32'h8000_0000), 0);
    send_request(make_alloc(16'(OSA_MAX_STACK_BYTES - OSA_ALIGN_BYTES), 32'h5A5A_A5A5), 0);
    send_request(make_alloc(16'(8 * OSA_ALIGN_BYTES), 32'h0F0F_F0F0), 0);
    send_request(make_alloc(16'(OSA_ALIGN_BYTES), 32'h7FFF_FFFF), 0);
    send_request(make_alloc(16'(OSA_MAX_STACK_BYTES), 32'hDEAD_BEEF), 0);
    send_request(make_alloc(16'(OSA_ALIGN_BYTES), 32'h0BAD_F00D), 0);
    send_request(make_alloc(16'(OSA_ALIGN_BYTES), 32'hFFFF_FFFF), 0);
  endtask

  // hits on the first and last slot, a foreign owner, a zero owner and a
  // handle just past the table
  task automatic test_owned_lookups();
    send_request(make_lookup(8'd1, 32'hFFFF_FFFF), 0);
    send_request(make_lookup(8'(OSA_ENTRIES), 32'hDEAD_BEEF), 0);
    send_request(make_lookup(8'd2, 32'hA5A5_5A5A), 0);
    send_request(make_lookup(8'd3, 32'h0000_0000), 0);
    send_request(make_lookup(8'(OSA_ENTRIES + 1), 32'h0000_0001), 0);
  endtask

  // one phase of random traffic under a fresh pool base; the sender pauses
  // until every owed result is in before the register is touched
  task automatic test_random_traffic(input logic [31:0] pool_base, input int unsigned idle_pct);
    wait_results_drained();
    write_pool_base(pool_base);
    repeat (PHASE_REQUESTS) send_request(random_request(), idle_pct);
  endtask

  initial begin
    for (int i = 0; i < OSA_ENTRIES; i++) begin
      slot_used_m[i]  = 1'b0;
      slot_owner_m[i] = '0;
      slot_size_m[i]  = '0;
    end
    pool_base_m = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // top of the address space so that slot addresses wrap
    write_pool_base(32'hFFFF_FFF8);
    test_empty_table();
    test_bad_allocations();
    test_fill_and_overflow();
    test_owned_lookups();

    test_random_traffic(32'($urandom()) & 32'hFFFF_FFF8, 0);
    test_random_traffic(32'h0000_0000, 72);
    test_random_traffic(32'($urandom()) & 32'hFFFF_FFF8, 28);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) begin
      $display("%0t: results left owed, expected 0, actual %0d", $time, expected_rsp_q.size());
      error_count++;
    end

    $display("summary: %0d requests, %0d results checked, %0d pool base settings",
             requests_sent, results_checked, base_writes);
    $display("summary: ok %0d, bad %0d, owner held %0d, full %0d, miss %0d",
             status_count[ST_OK], status_count[ST_BAD], status_count[ST_DUP],
             status_count[ST_FULL], status_count[ST_MISS]);
    if (error_count == 0) begin
      $display("owned_slot_allocator_unit verification clean");
    end else begin
      $display("owned_slot_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

@@ owned_slot_allocator_unit.f @@
rtl/osa_pkg.sv
rtl/osa_ram.sv
rtl/owned_slot_allocator_unit.sv
dv/tb.sv
